### rtl/core/pcq_pkg.sv
// Shared types and constants of the priority command queue.
`timescale 1ns / 1ps

package pcq_pkg;

   // Fixed field widths
   localparam int unsigned PAYLOAD_WIDTH   = 32;
   localparam int unsigned RETRY_WIDTH     = 8;
   localparam int unsigned LIMIT_WIDTH     = 5;
   localparam int unsigned CSR_DATA_WIDTH  = 8;
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned ENTRY_WIDTH     = 1 + RETRY_WIDTH + PAYLOAD_WIDTH;
   localparam int unsigned TOTAL_WIDTH     = 32;

   // Default ring size
   localparam int unsigned QUEUE_DEPTH_DEF = 16;

   // Register reset values
   localparam logic [LIMIT_WIDTH-1:0] DEPTH_LIMIT_RESET = 5'd16;
   localparam logic [RETRY_WIDTH-1:0] RETRY_LIMIT_RESET = 8'd3;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DEPTH_LIMIT = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RETRY_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_RETRY = 2'd1,
      OP_POP   = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_EMPTY     = 2'd2,
      STAT_EXHAUSTED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;    // latch the request beat
      logic commit;    // execute the latched operation
      logic pop_load;  // capture the popped entry from the ring
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic pop_hit;   // latched operation is a pop on a non-empty queue
      logic rsp_busy;  // result register holds a beat that is not taken this cycle
   } dp_status_type;

   // One result beat
   typedef struct packed {
      logic [TOTAL_WIDTH-1:0]   pop_total;
      logic [TOTAL_WIDTH-1:0]   push_total;
      logic                     is_full;
      logic                     is_empty;
      logic [LIMIT_WIDTH-1:0]   fill_level;
      logic [PAYLOAD_WIDTH-1:0] out_payload;
      logic [RETRY_WIDTH-1:0]   out_retry_count;
      logic                     out_is_abort;
      status_type               status;
   } rsp_beat_type;

endpackage

### rtl/core/pcq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pcq_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/pcq_ctrl.sv
// Sequencing state machine of the priority command queue.
`timescale 1ns / 1ps

module pcq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  pcq_pkg::dp_status_type  dp_status,
   output pcq_pkg::ctrl_cmd_type   cmd
);

   pcq_pkg::state_type state_ff;
   pcq_pkg::state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pcq_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = pcq_pkg::ST_EXEC;
            end
         end
         pcq_pkg::ST_EXEC: begin
            if (!dp_status.rsp_busy) begin
               state_in = dp_status.pop_hit ? pcq_pkg::ST_READ : pcq_pkg::ST_IDLE;
            end
         end
         pcq_pkg::ST_READ: begin
            state_in = pcq_pkg::ST_IDLE;
         end
         default: begin
            state_in = pcq_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_ready    = 1'b0;
      cmd.accept   = 1'b0;
      cmd.commit   = 1'b0;
      cmd.pop_load = 1'b0;
      case (state_ff)
         pcq_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         pcq_pkg::ST_EXEC: begin
            cmd.commit = !dp_status.rsp_busy;
         end
         pcq_pkg::ST_READ: begin
            cmd.pop_load = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/pcq_datapath.sv
// Ring storage, pointers, totals, limits and result register of the queue.
`timescale 1ns / 1ps

module pcq_datapath #(
   parameter int unsigned QUEUE_DEPTH = pcq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pcq_pkg::ctrl_cmd_type                 cmd,
   output pcq_pkg::dp_status_type                dp_status,
   input  logic [1:0]                            req_operation,
   input  logic                                  req_cmd_is_abort,
   input  logic [pcq_pkg::RETRY_WIDTH-1:0]       req_cmd_retry_count,
   input  logic [pcq_pkg::PAYLOAD_WIDTH-1:0]     req_cmd_payload,
   input  logic                                  csr_write,
   input  logic [pcq_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [pcq_pkg::CSR_DATA_WIDTH-1:0]    csr_data,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output pcq_pkg::rsp_beat_type                 rsp_beat
);

   localparam int unsigned LIMIT_W  = pcq_pkg::LIMIT_WIDTH;
   localparam int unsigned LIMIT_MAX = (1 << LIMIT_W) - 1;
   localparam int unsigned MAX_FILL = (QUEUE_DEPTH < LIMIT_MAX) ? QUEUE_DEPTH : LIMIT_MAX;
   localparam int unsigned CNT_W    = $clog2(MAX_FILL + 1);
   localparam int unsigned IDX_W    = $clog2(QUEUE_DEPTH);
   localparam int unsigned SUM_W    = IDX_W + 1;
   localparam int unsigned RW       = pcq_pkg::RETRY_WIDTH;
   localparam int unsigned PW       = pcq_pkg::PAYLOAD_WIDTH;
   localparam int unsigned EW       = pcq_pkg::ENTRY_WIDTH;
   localparam int unsigned TW       = pcq_pkg::TOTAL_WIDTH;

   // Limit registers
   logic [LIMIT_W-1:0] depth_limit_ff;
   logic [RW-1:0]      retry_limit_ff;

   // Latched request
   pcq_pkg::op_type op_ff;
   logic            abort_ff;
   logic [RW-1:0]   retry_ff;
   logic [PW-1:0]   payload_ff;

   // Queue state
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [TW-1:0]    push_total_ff, push_total_in;
   logic [TW-1:0]    pop_total_ff, pop_total_in;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   pcq_pkg::rsp_beat_type rsp_ff, rsp_in;

   // Operation decode
   logic [LIMIT_W-1:0] eff_limit;
   logic               ring_full;
   logic               retry_spent;
   logic               do_insert;
   logic               do_pop;
   logic               do_clear;
   pcq_pkg::status_type op_status;
   logic [IDX_W-1:0]   head_dec;
   logic [IDX_W-1:0]   head_inc;
   logic [SUM_W-1:0]   tail_sum;
   logic [SUM_W-1:0]   tail_wrap;
   logic [IDX_W-1:0]   tail_idx;
   logic [IDX_W-1:0]   head_after;
   logic [CNT_W-1:0]   count_after;
   logic [TW-1:0]      push_after;
   logic [TW-1:0]      pop_after;
   logic [RW-1:0]      store_retry;
   logic [EW-1:0]      wr_entry;
   logic [EW-1:0]      rd_entry;
   logic [IDX_W-1:0]   wr_addr;

   // Effective limit: never above what the ring holds
   assign eff_limit   = (depth_limit_ff > LIMIT_W'(MAX_FILL)) ? LIMIT_W'(MAX_FILL)
                                                             : depth_limit_ff;
   assign ring_full   = LIMIT_W'(count_ff) >= eff_limit;
   assign retry_spent = retry_ff >= retry_limit_ff;

   // Ring index arithmetic
   assign head_dec  = (head_ff == '0) ? IDX_W'(QUEUE_DEPTH - 1) : head_ff - IDX_W'(1);
   assign head_inc  = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail_wrap = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? tail_sum - SUM_W'(QUEUE_DEPTH)
                                                         : tail_sum;
   assign tail_idx  = tail_wrap[IDX_W-1:0];

   // Decide the outcome of the latched operation
   always_comb begin
      op_status = pcq_pkg::STAT_OK;
      do_insert = 1'b0;
      do_pop    = 1'b0;
      do_clear  = 1'b0;
      case (op_ff)
         pcq_pkg::OP_PUSH: begin
            if (ring_full) begin
               op_status = pcq_pkg::STAT_FULL;
            end else begin
               do_insert = 1'b1;
            end
         end
         pcq_pkg::OP_RETRY: begin
            if (retry_spent) begin
               op_status = pcq_pkg::STAT_EXHAUSTED;
            end else if (ring_full) begin
               op_status = pcq_pkg::STAT_FULL;
            end else begin
               do_insert = 1'b1;
            end
         end
         pcq_pkg::OP_POP: begin
            if (count_ff == '0) begin
               op_status = pcq_pkg::STAT_EMPTY;
            end else begin
               do_pop = 1'b1;
            end
         end
         pcq_pkg::OP_CLEAR: begin
            do_clear = 1'b1;
         end
         default: begin
            op_status = pcq_pkg::STAT_OK;
         end
      endcase
   end

   // Queue state after the operation
   always_comb begin
      head_after  = head_ff;
      count_after = count_ff;
      push_after  = push_total_ff;
      pop_after   = pop_total_ff;
      if (do_insert) begin
         if (abort_ff) begin
            head_after = head_dec;
         end
         count_after = count_ff + CNT_W'(1);
         push_after  = push_total_ff + TW'(1);
      end else if (do_pop) begin
         head_after  = head_inc;
         count_after = count_ff - CNT_W'(1);
         pop_after   = pop_total_ff + TW'(1);
      end else if (do_clear) begin
         head_after  = '0;
         count_after = '0;
      end
   end

   assign head_in       = cmd.commit ? head_after  : head_ff;
   assign count_in      = cmd.commit ? count_after : count_ff;
   assign push_total_in = cmd.commit ? push_after  : push_total_ff;
   assign pop_total_in  = cmd.commit ? pop_after   : pop_total_ff;

   // Entry written on insert: abort goes in front of the head, others at the tail
   assign store_retry = (op_ff == pcq_pkg::OP_RETRY) ? retry_ff + RW'(1) : retry_ff;
   assign wr_entry    = {abort_ff, store_retry, payload_ff};
   assign wr_addr     = abort_ff ? head_dec : tail_idx;

   pcq_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.commit && do_insert),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (cmd.commit && do_pop),
      .rd_addr (head_ff),
      .rd_data (rd_entry)
   );

   // Result register: status and counters on commit, popped entry in the following cycle
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.commit) begin
         rsp_in.status          = op_status;
         rsp_in.out_is_abort    = 1'b0;
         rsp_in.out_retry_count = '0;
         rsp_in.out_payload     = '0;
         rsp_in.fill_level      = LIMIT_W'(count_after);
         rsp_in.is_empty        = (count_after == '0);
         rsp_in.is_full         = LIMIT_W'(count_after) >= eff_limit;
         rsp_in.push_total      = push_after;
         rsp_in.pop_total       = pop_after;
      end else if (cmd.pop_load) begin
         rsp_in.out_is_abort    = rd_entry[EW-1];
         rsp_in.out_retry_count = rd_entry[PW +: RW];
         rsp_in.out_payload     = rd_entry[PW-1:0];
      end
   end

   // Raise valid when the beat is complete, drop it when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((cmd.commit && !do_pop) || cmd.pop_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign dp_status.pop_hit  = do_pop;
   assign dp_status.rsp_busy = rsp_valid_ff && !rsp_ready;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_limit_ff <= pcq_pkg::DEPTH_LIMIT_RESET;
         retry_limit_ff <= pcq_pkg::RETRY_LIMIT_RESET;
         head_ff        <= '0;
         count_ff       <= '0;
         push_total_ff  <= '0;
         pop_total_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         head_ff       <= head_in;
         count_ff      <= count_in;
         push_total_ff <= push_total_in;
         pop_total_ff  <= pop_total_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               pcq_pkg::REG_DEPTH_LIMIT: depth_limit_ff <= csr_data[LIMIT_W-1:0];
               pcq_pkg::REG_RETRY_LIMIT: retry_limit_ff <= csr_data[RW-1:0];
               default: begin
                  depth_limit_ff <= depth_limit_ff;
               end
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff      <= pcq_pkg::op_type'(req_operation);
         abort_ff   <= req_cmd_is_abort;
         retry_ff   <= req_cmd_retry_count;
         payload_ff <= req_cmd_payload;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

endmodule

### rtl/core/priority_command_queue_unit.sv
// Top level of the priority command queue: stream ports, controller and datapath.
`timescale 1ns / 1ps

// A bounded command queue kept in a ring RAM of QUEUE_DEPTH entries. Each request
// beat carries one operation (push, retry, pop, clear) and yields exactly one
// response beat with the status, the popped entry (zero unless a pop succeeds),
// the fill level after the operation and the running push and pop totals. Abort
// commands are inserted ahead of the head; all others go to the tail. Requests
// are taken one at a time: after acceptance the operation executes as soon as
// no earlier response is left waiting, and a successful pop then passes through
// a read state to capture its entry, because the ring RAM has a registered read
// port; the controller then returns to idle, so the next request is not taken
// before the last one is through. A response waiting on rsp_tready does not
// block acceptance of the next request. Limit registers are written through
// the csr port, which is always ready and should only be used while the queue
// is idle.
module priority_command_queue_unit #(
   parameter int unsigned QUEUE_DEPTH = pcq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [7:0] cmd_retry_count, [39:8] cmd_payload
   input  logic [39:0]                          req_tdata,
   // [1:0] operation, [2] cmd_is_abort
   input  logic [2:0]                           req_tuser,
   // Response stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] out_is_abort, [8:1] out_retry_count, [40:9] out_payload,
   // [45:41] fill_level, [46] is_empty, [47] is_full,
   // [79:48] push_total, [111:80] pop_total
   output logic [111:0]                         rsp_tdata,
   // [1:0] status
   output logic [1:0]                           rsp_tuser,
   // Register write port
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pcq_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [pcq_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);

   pcq_pkg::ctrl_cmd_type  cmd;
   pcq_pkg::dp_status_type dp_status;
   pcq_pkg::rsp_beat_type  rsp_beat;

   assign csr_ready = 1'b1;

   pcq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   pcq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .dp_status           (dp_status),
      .req_operation       (req_tuser[1:0]),
      .req_cmd_is_abort    (req_tuser[2]),
      .req_cmd_retry_count (req_tdata[7:0]),
      .req_cmd_payload     (req_tdata[39:8]),
      .csr_write           (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_ready           (rsp_tready),
      .rsp_valid           (rsp_tvalid),
      .rsp_beat            (rsp_beat)
   );

   // Pack the response beat
   assign rsp_tdata = {rsp_beat.pop_total,
                       rsp_beat.push_total,
                       rsp_beat.is_full,
                       rsp_beat.is_empty,
                       rsp_beat.fill_level,
                       rsp_beat.out_payload,
                       rsp_beat.out_retry_count,
                       rsp_beat.out_is_abort};
   assign rsp_tuser = rsp_beat.status;

`ifndef SYNTH
   // Empty flag agrees with the fill level
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_beat.is_empty == (rsp_beat.fill_level == '0)))
      else $error("is_empty disagrees with fill_level");

   // Entry fields are zero unless the beat reports success
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_beat.status != pcq_pkg::STAT_OK) |->
      (!rsp_beat.out_is_abort && rsp_beat.out_retry_count == '0 &&
       rsp_beat.out_payload == '0))
      else $error("failed operation returned entry data");

   // A full status always comes with is_full set
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_beat.status == pcq_pkg::STAT_FULL) |-> rsp_beat.is_full)
      else $error("full status without is_full");

   // One request at a time: no acceptance right after an acceptance
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is executing");
`endif

endmodule
